// ===== rtl/bimsu_pkg.sv =====
// Package for the biunique index move and shift unit.
// Holds field widths, the table entry layout, and operation and status codes.
// Depends on nothing.
package bimsu_pkg;

	localparam int ENTRIES_DEFAULT = 64;
	localparam int KEY_W = 6;
	localparam int FUNC_W = 2;
	localparam int STATUS_W = 2;

	typedef enum logic [FUNC_W-1:0] {
		FN_BIND = 2'd0,
		FN_MOVE = 2'd1,
		FN_LOOKUP = 2'd2
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK = 2'd0,
		ST_EMPTY = 2'd1,
		ST_NOROOM = 2'd2
	} status_t;

	typedef struct packed {
		logic vld;
		logic [KEY_W-1:0] idx;
	} entry_t;

endpackage

// ===== rtl/biunique_index_move_shift_unit.sv =====
// Top level of the biunique index move and shift unit: forward and reverse tables
// in two synchronous memories, driven by a one-hot sequencer.
// Depends on bimsu_pkg.
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  func, a_key, a_target, b_key
//  out      output     out_valid / out_stall b_value, status
//
// After reset a clearing pass writes every entry of both tables before the first word.
// Lookup passes through S_READ to S_RESP, bind through S_READ and S_SET, and a rejected word
// goes straight to S_RESP, which loads the result register. A move's gap search and shift
// each visit one entry per cycle through the forward memory's read port.
// A new word is taken whenever the sequencer is idle, even while a result waits on out_stall.
module biunique_index_move_shift_unit #(
	parameter int ENTRIES = bimsu_pkg::ENTRIES_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [bimsu_pkg::FUNC_W-1:0]   func,
	input  logic [bimsu_pkg::KEY_W-1:0]    a_key,
	input  logic [bimsu_pkg::KEY_W-1:0]    a_target,
	input  logic [bimsu_pkg::KEY_W-1:0]    b_key,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [bimsu_pkg::KEY_W-1:0]    b_value,
	output logic [bimsu_pkg::STATUS_W-1:0] status
);

	localparam int KW = bimsu_pkg::KEY_W;
	localparam int AW = $clog2(ENTRIES);
	localparam int CW = AW + 1;

	typedef logic [AW-1:0] idx_t;

	typedef enum logic [8:0] {
		S_CLEAR  = 9'b000000001,
		S_IDLE   = 9'b000000010,
		S_READ   = 9'b000000100,
		S_SEARCH = 9'b000001000,
		S_VAC    = 9'b000010000,
		S_SHIFT  = 9'b000100000,
		S_SET    = 9'b001000000,
		S_RESP   = 9'b010000000,
		S_SPARE  = 9'b100000000
	} state_t;

	function automatic logic in_range(input logic [KW-1:0] key);
		return ENTRIES > 32'(key);
	endfunction

	bimsu_pkg::entry_t fwd_mem [ENTRIES];
	bimsu_pkg::entry_t rev_mem [ENTRIES];
	bimsu_pkg::entry_t fwd_rd_q, rev_rd_q;

	logic fwd_we, rev_we;
	idx_t fwd_wa, rev_wa, fwd_ra, rev_ra;
	bimsu_pkg::entry_t fwd_wd, rev_wd;

	state_t state_q, state_d;
	logic [bimsu_pkg::FUNC_W-1:0] func_q;
	logic [KW-1:0] ak_q, at_q, bk_q, b_q, b_d;
	logic [CW-1:0] chk_q, chk_d, chk_nx;
	idx_t sh_q, sh_d, clr_q, ak_idx, at_idx;
	logic [KW-1:0] res_b_q, res_b_d, set_a;
	bimsu_pkg::status_t res_st_q, res_st_d, status_q;
	logic [KW-1:0] b_value_q;
	logic out_valid_q, out_free, er_live;
	bimsu_pkg::entry_t ef, er;

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign b_value = b_value_q;
	assign status = status_q;
	assign out_free = !out_valid_q || !out_stall;

	assign ef = fwd_rd_q;
	assign er = rev_rd_q;
	assign ak_idx = idx_t'(ak_q);
	assign at_idx = idx_t'(at_q);
	assign chk_nx = chk_q + CW'(1);
	assign rev_ra = idx_t'(b_key);
	assign set_a = (func_q == bimsu_pkg::FN_MOVE) ? at_q : ak_q;
	assign er_live = er.vld && !(ef.vld && in_range(ef.idx) && (ef.idx == bk_q));

	always_ff @(posedge clk) begin
		if (fwd_we) begin
			fwd_mem[fwd_wa] <= fwd_wd;
		end
		fwd_rd_q <= fwd_mem[fwd_ra];
	end

	always_ff @(posedge clk) begin
		if (rev_we) begin
			rev_mem[rev_wa] <= rev_wd;
		end
		rev_rd_q <= rev_mem[rev_ra];
	end

	always_comb begin
		state_d = state_q;
		chk_d = chk_q;
		sh_d = sh_q;
		b_d = b_q;
		res_b_d = res_b_q;
		res_st_d = res_st_q;
		fwd_we = 1'b0;
		fwd_wa = '0;
		fwd_wd = '0;
		fwd_ra = '0;
		rev_we = 1'b0;
		rev_wa = '0;
		rev_wd = '0;
		unique case (state_q)
			S_CLEAR: begin
				fwd_we = 1'b1;
				fwd_wa = clr_q;
				rev_we = 1'b1;
				rev_wa = clr_q;
				if (clr_q == idx_t'(ENTRIES - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				fwd_ra = idx_t'(a_key);
				res_b_d = '0;
				if (in_valid) begin
					unique case (func)
						bimsu_pkg::FN_BIND: begin
							if (in_range(a_key) && in_range(b_key)) begin
								state_d = S_READ;
							end else begin
								res_st_d = bimsu_pkg::ST_NOROOM;
								state_d = S_RESP;
							end
						end
						bimsu_pkg::FN_MOVE, bimsu_pkg::FN_LOOKUP: begin
							if (in_range(a_key)) begin
								state_d = S_READ;
							end else begin
								res_st_d = bimsu_pkg::ST_EMPTY;
								state_d = S_RESP;
							end
						end
						default: begin
							res_st_d = bimsu_pkg::ST_OK;
							state_d = S_RESP;
						end
					endcase
				end
			end
			S_READ: begin
				fwd_ra = at_idx;
				unique case (func_q)
					bimsu_pkg::FN_BIND: begin
						if (ef.vld && in_range(ef.idx)) begin
							rev_we = 1'b1;
							rev_wa = idx_t'(ef.idx);
						end
						if (er_live && in_range(er.idx)) begin
							fwd_we = 1'b1;
							fwd_wa = idx_t'(er.idx);
						end
						b_d = bk_q;
						state_d = S_SET;
					end
					bimsu_pkg::FN_LOOKUP: begin
						if (ef.vld) begin
							res_b_d = ef.idx;
							res_st_d = bimsu_pkg::ST_OK;
						end else begin
							res_st_d = bimsu_pkg::ST_EMPTY;
						end
						state_d = S_RESP;
					end
					bimsu_pkg::FN_MOVE: begin
						priority if (!ef.vld) begin
							res_st_d = bimsu_pkg::ST_EMPTY;
							state_d = S_RESP;
						end else if (at_q == ak_q) begin
							res_b_d = ef.idx;
							res_st_d = bimsu_pkg::ST_OK;
							state_d = S_RESP;
						end else if (!in_range(at_q)) begin
							res_st_d = bimsu_pkg::ST_NOROOM;
							state_d = S_RESP;
						end else begin
							b_d = ef.idx;
							chk_d = CW'(at_q);
							state_d = S_SEARCH;
						end
					end
					default: begin
						state_d = S_RESP;
					end
				endcase
			end
			S_SEARCH: begin
				fwd_ra = chk_nx[AW-1:0];
				priority if ((32'(chk_q) == 32'(ak_q)) || !ef.vld) begin
					sh_d = chk_q[AW-1:0];
					state_d = S_VAC;
				end else if (chk_nx == CW'(ENTRIES)) begin
					res_st_d = bimsu_pkg::ST_NOROOM;
					state_d = S_RESP;
				end else begin
					chk_d = chk_nx;
				end
			end
			S_VAC: begin
				fwd_we = 1'b1;
				fwd_wa = ak_idx;
				fwd_ra = sh_q - idx_t'(1);
				if (sh_q == at_idx) begin
					state_d = S_SET;
				end else begin
					state_d = S_SHIFT;
				end
			end
			S_SHIFT: begin
				fwd_ra = sh_q - idx_t'(2);
				if (ef.vld) begin
					fwd_we = 1'b1;
					fwd_wa = sh_q;
					fwd_wd = ef;
					if (in_range(ef.idx)) begin
						rev_we = 1'b1;
						rev_wa = idx_t'(ef.idx);
						rev_wd.vld = 1'b1;
						rev_wd.idx = KW'(sh_q);
					end
				end
				if (idx_t'(sh_q - idx_t'(1)) == at_idx) begin
					state_d = S_SET;
				end else begin
					sh_d = sh_q - idx_t'(1);
				end
			end
			S_SET: begin
				fwd_we = 1'b1;
				fwd_wa = idx_t'(set_a);
				fwd_wd.vld = 1'b1;
				fwd_wd.idx = b_q;
				rev_we = 1'b1;
				rev_wa = idx_t'(b_q);
				rev_wd.vld = 1'b1;
				rev_wd.idx = set_a;
				res_b_d = b_q;
				res_st_d = bimsu_pkg::ST_OK;
				state_d = S_RESP;
			end
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			chk_q <= '0;
			sh_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			chk_q <= chk_d;
			sh_q <= sh_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + idx_t'(1);
			end
			if ((state_q == S_RESP) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && in_valid) begin
			func_q <= func;
			ak_q <= a_key;
			at_q <= a_target;
			bk_q <= b_key;
		end
		b_q <= b_d;
		res_b_q <= res_b_d;
		res_st_q <= res_st_d;
		if ((state_q == S_RESP) && out_free) begin
			b_value_q <= res_b_q;
			status_q <= res_st_q;
		end
	end

	a_rise_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_RESP))
		else $error("result word appeared outside the response state");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q != S_IDLE))
		else $error("accepted word did not start the sequencer");

	a_search_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH) |-> (32'(chk_q) < ENTRIES))
		else $error("gap search pointer left the table");

	a_resp_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_RESP) && out_free) |=> (out_valid_q && (state_q == S_IDLE)))
		else $error("response did not reach the output register");

endmodule
